// ----- design/grd_pkg.sv -----
// ----------------------------------------------------------------------------
// grd_pkg: shared types and constants for the graph reachability block
// Field widths, command codes and status codes.
// ----------------------------------------------------------------------------
package grd_pkg;

  localparam int FUNC_W   = 2;
  localparam int VTX_W    = 6;
  localparam int STATUS_W = 2;
  localparam int VCNT_W   = 7;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [VTX_W-1:0]    vtx_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [VCNT_W-1:0]   vcnt_t;

  // command codes
  localparam func_t FUNC_EDGE  = 2'd0;
  localparam func_t FUNC_QUERY = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  // status codes
  localparam status_t ST_EDGE_STORED = 2'd0;
  localparam status_t ST_ANSWERED    = 2'd1;
  localparam status_t ST_CLEARED     = 2'd2;
  localparam status_t ST_RANGE_ERR   = 2'd3;

  localparam vcnt_t VCNT_RESET = 7'd64;

endpackage

// ----- design/grd_req_if.sv -----
// ----------------------------------------------------------------------------
// grd_req_if: request channel
// Valid/ready channel carrying one command with its two vertex fields.
// ----------------------------------------------------------------------------
interface grd_req_if import grd_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  vtx_t  vertex_a;
  vtx_t  vertex_b;

  modport source (output valid, func, vertex_a, vertex_b, input ready);
  modport sink   (input valid, func, vertex_a, vertex_b, output ready);
endinterface

// ----- design/grd_res_if.sv -----
// ----------------------------------------------------------------------------
// grd_res_if: result channel
// Valid/ready channel carrying the answer and status of one request.
// ----------------------------------------------------------------------------
interface grd_res_if import grd_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    reachable;
  status_t status;

  modport source (output valid, reachable, status, input ready);
  modport sink   (input valid, reachable, status, output ready);
endinterface

// ----- design/grd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// grd_cfg_if: configuration write channel
// Valid/ready channel carrying the vertex count register value.
// ----------------------------------------------------------------------------
interface grd_cfg_if import grd_pkg::*; ();
  logic  valid;
  logic  ready;
  vcnt_t vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

// ----- design/graph_reachability_dfs.sv -----
// ----------------------------------------------------------------------------
// graph_reachability_dfs: undirected graph store with reachability queries
// Adjacency bit matrix in a single-port-read memory, walked by a small
// sequencer that expands one vertex at a time, a pick step then a scan step.
// ----------------------------------------------------------------------------
// The block keeps an undirected graph of up to MAX_VERTICES vertices as one
// adjacency row per vertex. An edge request sets both directions, a query
// request answers whether vertex_b can be reached from vertex_a, and a clear
// request empties the graph by dropping the per-row valid flags (no clearing
// sweep is needed, also not after reset). For edge and query requests, any
// vertex at or above min(vertex_count, MAX_VERTICES) gives status 3 and
// changes nothing; func 3 does the same. Exactly one result comes back per
// request, in order. With one request in flight at a time, clear and
// flagged requests go straight to S_DONE, an edge is a read-modify-write of
// two rows through the one memory port, and a query alternates a pick and a
// scan step per expanded vertex until the target is marked visited or the
// walk runs dry, paced by the adjacency memory's single registered read
// port: each expanded vertex needs one row read and a step to merge that row
// into the visited and pending masks. The result register frees the request
// side as soon as a result is handed over; a new request is taken while the
// previous result still waits downstream. The configuration channel is
// always ready.
// ----------------------------------------------------------------------------
module graph_reachability_dfs import grd_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk,
  input  logic       rst,
  grd_req_if.sink    req,
  grd_res_if.source  res,
  grd_cfg_if.sink    cfg
);

  // vertex index width inside the store
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  // width wide enough for the limit compare and the input vertex fields
  localparam int LW0 = $clog2(MAX_VERTICES + 1);
  localparam int CW  = (LW0 > VCNT_W) ? LW0 : VCNT_W;
  localparam int XW  = (VW > VTX_W) ? VW : VTX_W;

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [VW-1:0]           vidx_t;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_EDGE_RD   = 7'b0000010,  // read row a
    S_EDGE_WR_A = 7'b0000100,  // write row a, read row b
    S_EDGE_WR_B = 7'b0001000,  // write row b
    S_QRY_PICK  = 7'b0010000,  // test target, pick next pending vertex
    S_QRY_SCAN  = 7'b0100000,  // merge its row into the masks
    S_DONE      = 7'b1000000   // hand result to the output register
  } state_t;

  state_t  state;
  vcnt_t   vertex_count;

  vidx_t   op_a;
  vidx_t   op_b;
  row_t    visited;
  row_t    pending;
  logic    res_reach;
  status_t res_status;

  logic    out_valid;
  logic    out_reach;
  status_t out_status;

  // adjacency store: rows plus a valid flag per row (invalid reads as empty)
  row_t    adj_mem [MAX_VERTICES];
  row_t    row_valid;
  row_t    rd_row;
  logic    rd_row_valid;
  vidx_t   mem_raddr;
  vidx_t   mem_waddr;
  row_t    mem_wdata;
  logic    mem_we;
  row_t    row_q;

  // limit check
  logic [CW-1:0] lim;
  logic [CW-1:0] vcnt_w;
  logic [CW-1:0] max_w;
  logic          in_range;
  logic [XW-1:0] a_wide;
  logic [XW-1:0] b_wide;
  vidx_t         a_idx;
  vidx_t         b_idx;

  // walk control
  vidx_t pick_idx;
  row_t  new_bits;
  logic  req_fire;
  logic  out_load;

  assign req_fire = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign res.valid     = out_valid;
  assign res.reachable = out_reach;
  assign res.status    = out_status;

  assign vcnt_w   = CW'(vertex_count);
  assign max_w    = CW'(MAX_VERTICES);
  assign lim      = (vcnt_w < max_w) ? vcnt_w : max_w;
  assign in_range = (CW'(req.vertex_a) < lim) && (CW'(req.vertex_b) < lim);
  assign a_wide   = XW'(req.vertex_a);
  assign b_wide   = XW'(req.vertex_b);
  assign a_idx    = a_wide[VW-1:0];
  assign b_idx    = b_wide[VW-1:0];

  assign row_q    = rd_row_valid ? rd_row : '0;
  assign new_bits = row_q & ~visited;

  // lowest pending vertex
  always_comb begin
    pick_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick_idx = VW'(i);
      end
    end
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = op_a;
    mem_wdata = row_q | (row_t'(1) << op_b);
    case (state)
      S_EDGE_RD:   mem_raddr = op_a;
      S_EDGE_WR_A: begin
        mem_raddr = op_b;
        mem_we    = 1'b1;
      end
      S_EDGE_WR_B: begin
        mem_raddr = op_b;
        mem_we    = 1'b1;
        mem_waddr = op_b;
        mem_wdata = row_q | (row_t'(1) << op_a);
      end
      S_QRY_PICK:  mem_raddr = pick_idx;
      default:     mem_raddr = op_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[mem_waddr] <= mem_wdata;
    end
    rd_row       <= adj_mem[mem_raddr];
    rd_row_valid <= row_valid[mem_raddr];
  end

  assign out_load = (state == S_DONE) && (!out_valid || res.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VCNT_RESET;
      row_valid    <= '0;
      visited      <= '0;
      pending      <= '0;
      out_valid    <= 1'b0;
      op_a         <= '0;
      op_b         <= '0;
      res_reach    <= 1'b0;
      res_status   <= ST_RANGE_ERR;
    end else begin
      if (cfg.valid && cfg.ready) begin
        vertex_count <= cfg.vertex_count;
      end
      if (mem_we) begin
        row_valid[mem_waddr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            op_a       <= a_idx;
            op_b       <= b_idx;
            res_reach  <= 1'b0;
            res_status <= ST_RANGE_ERR;
            state      <= S_DONE;
            case (req.func)
              FUNC_EDGE: begin
                if (in_range) begin
                  state <= S_EDGE_RD;
                end
              end
              FUNC_QUERY: begin
                if (in_range) begin
                  visited <= row_t'(1) << a_idx;
                  pending <= row_t'(1) << a_idx;
                  state   <= S_QRY_PICK;
                end
              end
              FUNC_CLEAR: begin
                row_valid  <= '0;
                res_status <= ST_CLEARED;
              end
              default: ;
            endcase
          end
        end
        S_EDGE_RD:   state <= S_EDGE_WR_A;
        S_EDGE_WR_A: state <= S_EDGE_WR_B;
        S_EDGE_WR_B: begin
          res_status <= ST_EDGE_STORED;
          state      <= S_DONE;
        end
        S_QRY_PICK: begin
          if (visited[op_b]) begin
            res_reach  <= 1'b1;
            res_status <= ST_ANSWERED;
            state      <= S_DONE;
          end else if (pending == '0) begin
            res_status <= ST_ANSWERED;
            state      <= S_DONE;
          end else begin
            pending[pick_idx] <= 1'b0;
            state             <= S_QRY_SCAN;
          end
        end
        S_QRY_SCAN: begin
          visited <= visited | new_bits;
          pending <= pending | new_bits;
          state   <= S_QRY_PICK;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reach  <= res_reach;
      out_status <= res_status;
    end
  end

endmodule

// ----- bench/tb_graph_reachability_dfs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_reachability_dfs: self-checking bench for the reachability block
// Drives edge, query, clear and malformed requests with random idling on
// both channels. A behavioural copy of the graph predicts every answer, and
// each result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_graph_reachability_dfs;
  import grd_pkg::*;

  localparam int NUM_VERTICES = 64;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 300;
  // Long enough for a full walk plus the longest receiver hold-off, many times over.
  localparam int STUCK_LIMIT  = 5000;
  localparam int REPORT_MAX   = 10;

  // func 3 has no package name; the block must flag it
  localparam func_t FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic    reachable;
    status_t status;
  } answer_t;

  logic clk;
  logic rst;

  grd_req_if req ();
  grd_res_if res ();
  grd_cfg_if cfg ();

  graph_reachability_dfs #(.MAX_VERTICES(NUM_VERTICES)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg)
  );

  // --------------------------------------------------------------------------
  // Behavioural copy of the graph and the vertex count register
  // --------------------------------------------------------------------------
  logic [NUM_VERTICES-1:0] adj_rows [NUM_VERTICES];
  vcnt_t                   vertex_count_reg;

  answer_t pending_answers [$];

  int  err_count;
  int  served_items;   // requests the block acts on (not flagged)
  int  n_edges, n_queries, n_reached, n_clears, n_flagged, n_count_writes;
  bit  idle_on;        // random gaps on both channels
  int  hold_seq;       // bump to start the receiver's long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Closure over the stored edges. Every stored edge is followed, also edges
  // to vertices above the current count: the count only gates new requests.
  function automatic logic path_exists(vtx_t src, vtx_t dst);
    logic [NUM_VERTICES-1:0] seen, frontier, reached_next;
    seen      = '0;
    seen[src] = 1'b1;
    frontier  = seen;
    while (frontier != '0) begin
      reached_next = '0;
      for (int v = 0; v < NUM_VERTICES; v++) begin
        if (frontier[v]) reached_next |= adj_rows[v];
      end
      frontier = reached_next & ~seen;
      seen    |= reached_next;
    end
    return seen[dst];
  endfunction

  // Applies one request to the copy of the graph and returns its answer.
  function automatic void predict_request(input func_t f, input vtx_t a, input vtx_t b,
                                          output answer_t ans);
    int lim;
    lim = (int'(vertex_count_reg) < NUM_VERTICES) ? int'(vertex_count_reg) : NUM_VERTICES;
    ans.reachable = 1'b0;
    ans.status    = ST_RANGE_ERR;
    if (f == FUNC_CLEAR) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      ans.status = ST_CLEARED;
      n_clears++;
    end else if ((f == FUNC_EDGE || f == FUNC_QUERY) && int'(a) < lim && int'(b) < lim) begin
      if (f == FUNC_EDGE) begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
        ans.status     = ST_EDGE_STORED;
        n_edges++;
      end else begin
        ans.reachable = path_exists(a, b);
        ans.status    = ST_ANSWERED;
        n_queries++;
        if (ans.reachable) n_reached++;
      end
    end
    if (ans.status == ST_RANGE_ERR) n_flagged++;
    else served_items++;
  endfunction

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= REPORT_MAX) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Request side. valid is left high after acceptance; the next send or a
  // drain decides what it does next, so it is assigned once per edge.
  // --------------------------------------------------------------------------
  task automatic send_request(input func_t f, input vtx_t a, input vtx_t b);
    int      gap;
    answer_t ans;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.func     <= f;
    req.vertex_a <= a;
    req.vertex_b <= b;
    do @(posedge clk); while (!req.ready);
    predict_request(f, a, b, ans);
    pending_answers = {pending_answers, ans};
  endtask

  // Stop offering and wait for every outstanding answer. Each request gives
  // exactly one result, so an empty queue means the block is idle.
  task automatic wait_for_answers();
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_vertex_count(input vcnt_t count);
    wait_for_answers();
    cfg.valid        <= 1'b1;
    cfg.vertex_count <= count;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid        <= 1'b0;
    vertex_count_reg  = count;
    n_count_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls per result, plus the long hold-off on demand
  // --------------------------------------------------------------------------
  initial begin
    int wait_left;
    int hold_seen;
    wait_left = 0;
    hold_seen = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        wait_left = 0;
      end else if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        wait_left = HOLD_CYCLES;
      end else if (res.valid && res.ready) begin
        wait_left = idle_on ? $urandom_range(0, 3) : 0;
      end else if (wait_left > 0) begin
        wait_left--;
      end
      res.ready <= !rst && (wait_left == 0);
    end
  end

  // Compare every accepted result with the oldest outstanding answer
  initial begin
    answer_t want;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        if (pending_answers.size() == 0) begin
          note_failure($sformatf("result with none outstanding: reachable=%0d status=%0d",
                                 res.reachable, res.status));
        end else begin
          want = pending_answers.pop_front();
          if (res.reachable !== want.reachable)
            note_failure($sformatf("reachable: expected %0d, got %0d (status %0d)",
                                   want.reachable, res.reachable, want.status));
          if (res.status !== want.status)
            note_failure($sformatf("status: expected %0d, got %0d",
                                   want.status, res.status));
        end
      end
    end
  end

  // Watchdog: too long with no request, result or register write accepted
  initial begin
    int stuck;
    stuck = 0;
    forever begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (res.valid && res.ready)
          || (cfg.valid && cfg.ready))
        stuck = 0;
      else
        stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("timeout after %0d cycles without progress", STUCK_LIMIT);
        $display("tb_graph_reachability_dfs: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Full count: corner vertices, self loop, source equal to target, a path.
  task automatic test_basic_walks();
    idle_on = 1'b1;
    send_request(FUNC_QUERY, 6'd5, 6'd5);    // same vertex, no edges at all
    send_request(FUNC_QUERY, 6'd0, 6'd63);   // empty graph
    send_request(FUNC_EDGE,  6'd0, 6'd63);
    send_request(FUNC_EDGE,  6'd63, 6'd63);  // self loop
    send_request(FUNC_QUERY, 6'd63, 6'd0);   // reverse direction of the edge
    send_request(FUNC_EDGE,  6'd10, 6'd20);
    send_request(FUNC_EDGE,  6'd30, 6'd20);
    send_request(FUNC_QUERY, 6'd10, 6'd30);  // two hops
    send_request(FUNC_QUERY, 6'd30, 6'd0);   // other component
    send_request(FUNC_EDGE,  6'd42, 6'd21);  // all vertex bits both ways
  endtask

  // Unknown command and clear, the latter with junk in the vertex fields.
  task automatic test_command_codes();
    send_request(FUNC_UNUSED, 6'd0, 6'd63);
    send_request(FUNC_UNUSED, 6'd21, 6'd42);
    send_request(FUNC_CLEAR,  6'd63, 6'd63);
    send_request(FUNC_QUERY,  6'd0, 6'd63);  // edge gone after clear
    send_request(FUNC_QUERY,  6'd63, 6'd63);
  endtask

  // Count below the full size, lowered after edges, 1, 0 and above the maximum.
  task automatic test_vertex_limit();
    send_request(FUNC_EDGE, 6'd2, 6'd40);
    send_request(FUNC_EDGE, 6'd40, 6'd5);
    set_vertex_count(7'd8);
    send_request(FUNC_QUERY, 6'd2, 6'd5);    // walk goes through vertex 40
    send_request(FUNC_EDGE,  6'd7, 6'd0);
    send_request(FUNC_EDGE,  6'd8, 6'd1);    // first vertex out of range
    send_request(FUNC_QUERY, 6'd1, 6'd8);    // second vertex out of range
    set_vertex_count(7'd1);
    send_request(FUNC_QUERY, 6'd0, 6'd0);
    send_request(FUNC_EDGE,  6'd0, 6'd1);
    set_vertex_count(7'd0);
    send_request(FUNC_QUERY, 6'd0, 6'd0);    // nothing is in range
    send_request(FUNC_CLEAR, 6'd0, 6'd0);    // clear still works
    set_vertex_count(7'd127);
    send_request(FUNC_EDGE,  6'd63, 6'd62);
    send_request(FUNC_QUERY, 6'd62, 6'd63);
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs
  // up into its request port; then the sender pauses until all is drained.
  task automatic test_backpressure();
    wait_for_answers();
    idle_on = 1'b0;
    hold_seq++;
    for (int i = 0; i < 12; i++)
      send_request((i % 3 == 0) ? FUNC_QUERY : FUNC_EDGE,
                   vtx_t'($urandom_range(0, 63)), vtx_t'($urandom_range(0, 63)));
    wait_for_answers();
    idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Random phases: each picks a count and an edge density, then grows a graph
  // and queries it. Clears are not always issued at phase start, so edges
  // often outlive a lowered count.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic();
    vcnt_t counts [10] = '{7'd64, 7'd64, 7'd64, 7'd16, 7'd8, 7'd2, 7'd1, 7'd0, 7'd127, 7'd40};
    int    target, lim, phase_len, edge_pct, roll;
    target = served_items + n_flagged + RANDOM_ITEMS;
    while (served_items + n_flagged < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      set_vertex_count(($urandom_range(0, 4) == 0) ? vcnt_t'($urandom_range(0, 127))
                                                  : counts[$urandom_range(0, 9)]);
      lim = (int'(vertex_count_reg) < NUM_VERTICES) ? int'(vertex_count_reg) : NUM_VERTICES;
      if ($urandom_range(0, 1) == 0)
        send_request(FUNC_CLEAR, vtx_t'($urandom_range(0, 63)), vtx_t'($urandom_range(0, 63)));
      phase_len = $urandom_range(40, 120);
      edge_pct  = $urandom_range(15, 50);
      for (int i = 0; i < phase_len && served_items + n_flagged < target; i++) begin
        roll = $urandom_range(0, 99);
        if (lim > 0 && roll < edge_pct)
          send_request(FUNC_EDGE, vtx_t'($urandom_range(0, lim - 1)),
                       vtx_t'($urandom_range(0, lim - 1)));
        else if (lim > 0 && roll < 85)
          send_request(FUNC_QUERY, vtx_t'($urandom_range(0, lim - 1)),
                       vtx_t'($urandom_range(0, lim - 1)));
        else if (roll < 88)
          send_request(FUNC_CLEAR, vtx_t'($urandom_range(0, 63)),
                       vtx_t'($urandom_range(0, 63)));
        else if (roll < 92)
          send_request(FUNC_UNUSED, vtx_t'($urandom_range(0, 63)),
                       vtx_t'($urandom_range(0, 63)));
        else
          // either kind with unconstrained vertices, often out of range
          send_request(($urandom_range(0, 1) == 0) ? FUNC_EDGE : FUNC_QUERY,
                       vtx_t'($urandom_range(0, 63)), vtx_t'($urandom_range(0, 63)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    err_count        = 0;
    served_items     = 0;
    n_edges          = 0;
    n_queries        = 0;
    n_reached        = 0;
    n_clears         = 0;
    n_flagged        = 0;
    n_count_writes   = 0;
    idle_on          = 1'b1;
    hold_seq         = 0;
    vertex_count_reg = VCNT_RESET;
    foreach (adj_rows[i]) adj_rows[i] = '0;

    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.func         <= FUNC_EDGE;
    req.vertex_a     <= '0;
    req.vertex_b     <= '0;
    cfg.valid        <= 1'b0;
    cfg.vertex_count <= VCNT_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_basic_walks();
    test_command_codes();
    test_vertex_limit();
    test_backpressure();
    test_random_traffic();
    set_vertex_count(VCNT_RESET);
    test_backpressure();

    wait_for_answers();
    repeat (30) @(posedge clk);
    if (pending_answers.size() != 0)
      note_failure($sformatf("%0d answers never arrived", pending_answers.size()));

    $display("run covered %0d edges, %0d queries (%0d reachable), %0d clears,",
             n_edges, n_queries, n_reached, n_clears);
    $display("  %0d flagged requests, %0d count writes, %0d errors",
             n_flagged, n_count_writes, err_count);
    if (err_count == 0)
      $display("tb_graph_reachability_dfs: PASS");
    else
      $display("tb_graph_reachability_dfs: FAIL");
    $finish;
  end

endmodule
